[rtl/gc_content_adjustment_factor_assert.svh]
// assertion macros used by the checker of this block
`ifndef GC_CONTENT_ADJUSTMENT_FACTOR_ASSERT_SVH
`define GC_CONTENT_ADJUSTMENT_FACTOR_ASSERT_SVH

// generic clocked property, off during reset
`define GCAF_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define GCAF_CHECK_NEXT(label, ante, cons, msg) \
   `GCAF_CHECK(label, ((ante) |=> (cons)), msg)

`endif

[rtl/gcaf_pkg.sv]
package gcaf_pkg;

   localparam int ID_WIDTH      = 32;
   localparam int PERCENT_WIDTH = 23;
   localparam int FACTOR_WIDTH  = 24;
   localparam int INDEX_WIDTH   = 7;
   localparam int CHAR_WIDTH    = 8;
   localparam int SCALE_WIDTH   = 7;

   localparam logic [SCALE_WIDTH-1:0] PERCENT_SCALE = 7'd100;

   localparam logic [CHAR_WIDTH-1:0] CASE_FOLD    = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_C_LOWER = 8'h63;
   localparam logic [CHAR_WIDTH-1:0] CHAR_G_LOWER = 8'h67;

   typedef enum logic {
      OP_TABLE_WRITE = 1'b0,
      OP_BASE        = 1'b1
   } opcode_type;

endpackage

[rtl/gcaf_ram.sv]
module gcaf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 101
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gcaf_div.sv]
module gcaf_div #(
   parameter int LENGTH_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   input  logic [LENGTH_BITS-1:0]                          gc_count,
   input  logic [LENGTH_BITS-1:0]                          base_count,
   output logic                                            done,
   output logic [gcaf_pkg::SCALE_WIDTH+FRACTION_BITS-1:0]  quotient
);

   localparam int SW  = gcaf_pkg::SCALE_WIDTH;
   localparam int QW  = SW + FRACTION_BITS;
   localparam int PW  = LENGTH_BITS + SW;
   localparam int CW  = $clog2(QW);

   logic [PW-1:0]          scaled;
   logic [LENGTH_BITS:0]   trial;
   logic [LENGTH_BITS:0]   diff;
   logic                   fits;
   logic [LENGTH_BITS-1:0] rem_in;
   logic [QW-1:0]          num_in;

   logic                   busy_ff;
   logic                   done_ff;
   logic [CW-1:0]          step_ff;
   logic [LENGTH_BITS-1:0] rem_ff;
   logic [QW-1:0]          num_ff;
   logic [LENGTH_BITS-1:0] divisor_ff;

   // gc count times 100; the division appends the fraction bits below it
   assign scaled = PW'(gc_count) * PW'(gcaf_pkg::PERCENT_SCALE);

   // restoring division, one quotient bit a cycle
   assign trial  = {rem_ff, num_ff[QW-1]};
   assign diff   = trial - {1'b0, divisor_ff};
   assign fits   = trial >= {1'b0, divisor_ff};
   assign rem_in = fits ? diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
   assign num_in = {num_ff[QW-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff    <= 1'b1;
            step_ff    <= CW'(QW - 1);
            rem_ff     <= scaled[PW-1:SW];
            num_ff     <= {scaled[SW-1:0], {FRACTION_BITS{1'b0}}};
            divisor_ff <= base_count;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            num_ff  <= num_in;
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

[rtl/gc_content_adjustment_factor.sv]
// channel | direction | fields
// req_    | in        | opcode, table_index, table_value, base_char, last_base, sequence_id
// rsp_    | out       | sequence_id_res, gc_percent, adjustment_factor
//
// table writes and bases that are not last do not stall requests
// a last base stalls requests through the division, done by the
// one-bit-per-cycle divider, then two table reads, a multiply and the output load
// reset clears the counts and control; table points are undefined until written
// a waiting response sits in the output register while requests keep flowing;
// a later last base holds in its final step until that response is taken
module gc_content_adjustment_factor #(
   parameter int TABLE_POINTS  = 101,
   parameter int LENGTH_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_opcode,
   input  logic [6:0]  req_table_index,
   input  logic [23:0] req_table_value,
   input  logic [7:0]  req_base_char,
   input  logic        req_last_base,
   input  logic [31:0] req_sequence_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sequence_id_res,
   output logic [22:0] rsp_gc_percent,
   output logic [23:0] rsp_adjustment_factor
);

   localparam int AW  = $clog2(TABLE_POINTS);
   localparam int SW  = gcaf_pkg::SCALE_WIDTH;
   localparam int QW  = SW + FRACTION_BITS;
   localparam int FW  = gcaf_pkg::FACTOR_WIDTH;
   localparam int PRW = FW + FRACTION_BITS + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ_LO,
      ST_READ_HI,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [LENGTH_BITS-1:0]       gc_count_ff;
   logic [LENGTH_BITS-1:0]       base_count_ff;
   logic [gcaf_pkg::ID_WIDTH-1:0] sid_ff;
   logic [QW-1:0]                p_ff;
   logic [FW-1:0]                lo_ff;
   logic signed [PRW-1:0]        prod_ff;
   logic                         rsp_valid_ff;
   logic [gcaf_pkg::ID_WIDTH-1:0] rsp_sid_ff;
   logic [gcaf_pkg::PERCENT_WIDTH-1:0] rsp_percent_ff;
   logic [FW-1:0]                rsp_factor_ff;

   logic                   accept;
   logic                   is_base;
   logic                   div_start;
   logic                   div_done;
   logic [QW-1:0]          div_quotient;
   logic [gcaf_pkg::CHAR_WIDTH-1:0] folded;
   logic                   is_gc;
   logic                   room;
   logic [LENGTH_BITS-1:0] gc_count_in;
   logic [LENGTH_BITS-1:0] base_count_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          lo_addr;
   logic [AW-1:0]          hi_addr;
   logic [FW-1:0]          rd_data;

   logic [SW-1:0]            ip;
   logic [SW:0]              ip_next;
   logic [FRACTION_BITS-1:0] fr;
   logic                     top_point;
   logic [FW-1:0]            hi_eff;
   logic signed [FW:0]       diff;
   logic signed [PRW-1:0]    prod_in;
   logic signed [PRW-1:0]    sum;
   logic                     out_free;
   logic                     rsp_load;

   assign accept    = req_valid && !req_stall;
   assign is_base   = req_opcode == gcaf_pkg::OP_BASE;
   assign div_start = accept && is_base && req_last_base;
   assign req_stall = state_ff != ST_IDLE;

   // base counting, stops at saturation
   assign folded        = req_base_char | gcaf_pkg::CASE_FOLD;
   assign is_gc         = (folded == gcaf_pkg::CHAR_C_LOWER) ||
                          (folded == gcaf_pkg::CHAR_G_LOWER);
   assign room          = base_count_ff != '1;
   assign base_count_in = room ? base_count_ff + 1'b1 : base_count_ff;
   assign gc_count_in   = (room && is_gc) ? gc_count_ff + 1'b1 : gc_count_ff;

   // table write port
   assign wr_en   = accept && !is_base &&
                    (32'(req_table_index) < 32'(TABLE_POINTS));
   assign wr_addr = AW'(req_table_index);

   // interpolation points
   assign ip        = p_ff[QW-1:FRACTION_BITS];
   assign fr        = p_ff[FRACTION_BITS-1:0];
   assign ip_next   = {1'b0, ip} + 1'b1;
   assign top_point = ip >= gcaf_pkg::PERCENT_SCALE;

   always_comb begin
      if (32'(ip) >= 32'(TABLE_POINTS - 1)) begin
         lo_addr = AW'(TABLE_POINTS - 1);
      end else begin
         lo_addr = AW'(ip);
      end
      if (32'(ip_next) >= 32'(TABLE_POINTS - 1)) begin
         hi_addr = AW'(TABLE_POINTS - 1);
      end else begin
         hi_addr = AW'(ip_next);
      end
   end

   assign rd_addr = (state_ff == ST_READ_HI) ? hi_addr : lo_addr;

   // lo + (hi - lo) * f, floored
   assign hi_eff   = top_point ? lo_ff : rd_data;
   assign diff     = $signed({1'b0, hi_eff}) - $signed({1'b0, lo_ff});
   assign prod_in  = diff * $signed({1'b0, fr});
   assign sum      = PRW'($signed({1'b0, lo_ff})) + (prod_ff >>> FRACTION_BITS);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_FINISH) && out_free;

   gcaf_ram #(
      .WIDTH (FW),
      .DEPTH (TABLE_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gcaf_div #(
      .LENGTH_BITS   (LENGTH_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .gc_count   (gc_count_in),
      .base_count (base_count_in),
      .done       (div_done),
      .quotient   (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gc_count_ff   <= '0;
         base_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && is_base) begin
                  if (req_last_base) begin
                     gc_count_ff   <= '0;
                     base_count_ff <= '0;
                     sid_ff        <= req_sequence_id;
                     state_ff      <= ST_DIVIDE;
                  end else begin
                     gc_count_ff   <= gc_count_in;
                     base_count_ff <= base_count_in;
                  end
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  p_ff     <= div_quotient;
                  state_ff <= ST_READ_LO;
               end
            end
            ST_READ_LO: begin
               state_ff <= ST_READ_HI;
            end
            ST_READ_HI: begin
               lo_ff    <= rd_data;
               state_ff <= ST_MULTIPLY;
            end
            ST_MULTIPLY: begin
               prod_ff  <= prod_in;
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_sid_ff     <= sid_ff;
                  rsp_percent_ff <= gcaf_pkg::PERCENT_WIDTH'(p_ff);
                  rsp_factor_ff  <= sum[FW-1:0];
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sequence_id_res   = rsp_sid_ff;
   assign rsp_gc_percent        = rsp_percent_ff;
   assign rsp_adjustment_factor = rsp_factor_ff;

endmodule

[rtl/gc_content_adjustment_factor_checker.sv]
`include "gc_content_adjustment_factor_assert.svh"

module gc_content_adjustment_factor_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [0:0]  req_opcode,
   input logic        req_last_base,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_sequence_id_res,
   input logic [22:0] rsp_gc_percent,
   input logic [23:0] rsp_adjustment_factor
);

   logic        req_accept;
   logic        ends_sequence;
   logic        rsp_waiting;
   logic        plain_accept;
   logic        last_accept;
   logic [78:0] rsp_payload;

   assign req_accept    = req_valid && !req_stall;
   assign ends_sequence = (req_opcode == gcaf_pkg::OP_BASE) && req_last_base;
   assign rsp_waiting   = rsp_valid && rsp_stall;
   assign plain_accept  = req_accept && !ends_sequence && !rsp_valid;
   assign last_accept   = req_accept && ends_sequence;
   assign rsp_payload   = {rsp_sequence_id_res, rsp_gc_percent, rsp_adjustment_factor};

   `GCAF_CHECK_NEXT(a_rsp_held, rsp_waiting, rsp_valid, "response dropped while stalled")

   `GCAF_CHECK_NEXT(a_rsp_stable, rsp_waiting, $stable(rsp_payload), "stalled response changed")

   `GCAF_CHECK_NEXT(a_no_spurious_rsp, plain_accept, !rsp_valid, "response without a last base")

   `GCAF_CHECK_NEXT(a_busy_after_last, last_accept, req_stall, "request taken during finish")

endmodule

bind gc_content_adjustment_factor gc_content_adjustment_factor_checker u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .req_opcode            (req_opcode),
   .req_last_base         (req_last_base),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_sequence_id_res   (rsp_sequence_id_res),
   .rsp_gc_percent        (rsp_gc_percent),
   .rsp_adjustment_factor (rsp_adjustment_factor)
);

[sim/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_POINTS  = 101;
   localparam int FRACTION_BITS = 16;
   localparam int LENGTH_BITS   = 16;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_ITEMS  = 600;
   localparam int LONG_RUN      = 300;
   localparam int RUN_SEQUENCE  = 50;
   localparam int IDLE_PERCENT  = 18;
   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      gcaf_pkg::opcode_type op;
      logic [6:0]  index;
      logic [23:0] value;
      logic [7:0]  base;
      logic        last;
      logic [31:0] id;
   } gc_request_type;

   typedef struct packed {
      logic [31:0] id;
      logic [22:0] percent;
      logic [23:0] factor;
   } gc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [0:0]  req_opcode = gcaf_pkg::OP_TABLE_WRITE;
   logic [6:0]  req_table_index = '0;
   logic [23:0] req_table_value = '0;
   logic [7:0]  req_base_char = '0;
   logic        req_last_base = 1'b0;
   logic [31:0] req_sequence_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_sequence_id_res;
   logic [22:0] rsp_gc_percent;
   logic [23:0] rsp_adjustment_factor;

   // predictor state
   logic [23:0]            factor_points [0:TABLE_POINTS-1];
   logic [LENGTH_BITS-1:0] gc_total = '0;
   logic [LENGTH_BITS-1:0] base_total = '0;

   gc_result_type gc_results_due [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   logic       no_idle = 1'b0;

   gc_content_adjustment_factor #(
      .TABLE_POINTS (TABLE_POINTS),
      .LENGTH_BITS  (LENGTH_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_table_index      (req_table_index),
      .req_table_value      (req_table_value),
      .req_base_char        (req_base_char),
      .req_last_base        (req_last_base),
      .req_sequence_id      (req_sequence_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sequence_id_res  (rsp_sequence_id_res),
      .rsp_gc_percent       (rsp_gc_percent),
      .rsp_adjustment_factor(rsp_adjustment_factor)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
   end

   function automatic bit predict_gc_factor(input gc_request_type r, output gc_result_type res);
      logic [63:0] pct, ip, fr, lo, hi, mix;
      res = '0;
      if (r.op == gcaf_pkg::OP_TABLE_WRITE) begin
         if (r.index < TABLE_POINTS) factor_points[r.index] = r.value;
         return 1'b0;
      end
      if (base_total != COUNT_MAX) begin
         base_total = base_total + 1'b1;
         if ((r.base | gcaf_pkg::CASE_FOLD) == gcaf_pkg::CHAR_C_LOWER ||
             (r.base | gcaf_pkg::CASE_FOLD) == gcaf_pkg::CHAR_G_LOWER)
            gc_total = gc_total + 1'b1;
      end
      if (!r.last) return 1'b0;
      pct = ((64'(gc_total) * gcaf_pkg::PERCENT_SCALE) << FRACTION_BITS) / 64'(base_total);
      ip  = pct >> FRACTION_BITS;
      fr  = pct & ((64'd1 << FRACTION_BITS) - 1);
      lo  = factor_points[(ip >= TABLE_POINTS) ? TABLE_POINTS - 1 : ip];
      if (ip >= gcaf_pkg::PERCENT_SCALE) begin
         mix = lo;
      end else begin
         hi  = factor_points[(ip + 1 >= TABLE_POINTS) ? TABLE_POINTS - 1 : ip + 1];
         mix = (lo * ((64'd1 << FRACTION_BITS) - fr) + hi * fr) >> FRACTION_BITS;
      end
      res.id      = r.id;
      res.percent = pct[22:0];
      res.factor  = mix[23:0];
      gc_total    = '0;
      base_total  = '0;
      return 1'b1;
   endfunction

   task automatic send_request(input gc_request_type r);
      gc_result_type res;
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= r.op;
      req_table_index <= r.index;
      req_table_value <= r.value;
      req_base_char   <= r.base;
      req_last_base   <= r.last;
      req_sequence_id <= r.id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_gc_factor(r, res)) gc_results_due = {gc_results_due, res};
   endtask

   task automatic write_point(input logic [6:0] index, input logic [23:0] value);
      gc_request_type r;
      r.op    = gcaf_pkg::OP_TABLE_WRITE;
      r.index = index;
      r.value = value;
      r.base  = 8'($urandom);
      r.last  = 1'($urandom);
      r.id    = $urandom;
      send_request(r);
   endtask

   task automatic send_base(input logic [7:0] base, input logic last, input logic [31:0] id);
      gc_request_type r;
      r.op    = gcaf_pkg::OP_BASE;
      r.index = 7'($urandom);
      r.value = 24'($urandom);
      r.base  = base;
      r.last  = last;
      r.id    = id;
      send_request(r);
   endtask

   function automatic logic [7:0] random_base(input int gc_bias);
      string gc_chars = "CGcg";
      string at_chars = "ATat";
      if ($urandom_range(99) < 15) return 8'($urandom);
      if ($urandom_range(99) < gc_bias) return gc_chars[$urandom_range(3)];
      return at_chars[$urandom_range(3)];
   endfunction

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (gc_results_due.size() != 0);
   endtask

   always @(posedge clock) begin
      gc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gc_results_due.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected response: id %h percent %h factor %h",
                        rsp_sequence_id_res, rsp_gc_percent, rsp_adjustment_factor);
         end else begin
            want = gc_results_due.pop_front();
            if (rsp_sequence_id_res !== want.id || rsp_gc_percent !== want.percent ||
                rsp_adjustment_factor !== want.factor) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: id %h/%h percent %h/%h factor %h/%h (expected/actual)",
                           want.id, rsp_sequence_id_res, want.percent, rsp_gc_percent,
                           want.factor, rsp_adjustment_factor);
            end
         end
      end
   end

   // every point is written before any sequence can read it
   task automatic test_table_load();
      for (int k = 0; k < TABLE_POINTS; k++) write_point(7'(k), 24'($urandom));
   endtask

   task automatic test_directed_cases();
      write_point(7'd127, 24'hFFFFFF);
      write_point(7'd101, 24'h000000);
      write_point(7'd100, 24'hFFFFFF);
      write_point(7'd0, 24'h000000);
      write_point(7'd33, 24'hFFFFFF);
      write_point(7'd34, 24'h000000);
      // all gc, top point only
      send_base("G", 1'b1, 32'hFFFFFFFF);
      // no gc
      send_base("A", 1'b1, 32'h00000000);
      // one third, interpolated between extremes
      send_base("c", 1'b0, $urandom);
      send_base("A", 1'b0, $urandom);
      send_base("T", 1'b1, 32'h5A5A5A5A);
      send_base("g", 1'b0, $urandom);
      send_base("C", 1'b0, $urandom);
      send_base(8'h00, 1'b0, $urandom);
      send_base(8'hFF, 1'b1, 32'hA5A5A5A5);
      // bytes that match c or g except in bit 7 after case folding, so not counted as gc
      send_base(8'hE3, 1'b0, $urandom);
      send_base(8'hC7, 1'b0, $urandom);
      send_base("G", 1'b1, $urandom);
   endtask

   // long stretch with no idling on either side
   task automatic test_back_to_back_run();
      no_idle <= 1'b1;
      for (int k = 1; k <= LONG_RUN; k++)
         send_base(random_base(70), (k % RUN_SEQUENCE) == 0, $urandom);
      wait_for_results();
      no_idle <= 1'b0;
   endtask

   task automatic test_random_sequences();
      int sent;
      int len;
      int gc_bias;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(1, 3)) begin
               write_point(7'($urandom_range(0, 127)), 24'($urandom));
               sent++;
            end
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
         gc_bias = $urandom_range(100);
         for (int k = 1; k <= len; k++) begin
            send_base(random_base(gc_bias), k == len, $urandom);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_directed_cases();
      wait_for_results();
      test_back_to_back_run();
      test_random_sequences();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && gc_results_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
